@@ rtl/core/u2u8_pkg.sv @@
// shared types for the utf-16 to utf-8 transcoder
// no dependencies
`default_nettype none

package u2u8_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW   = 3;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             string_end;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] utf8_byte;
    logic             run_last;
  } out_t;

  // encoder result for one unit: bytes in order from index 0, and how many
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
  } enc_t;

  localparam logic [5:0] HighSurTag = 6'b110110;
  localparam logic [5:0] LowSurTag  = 6'b110111;
  localparam logic [4:0] SurTag     = 5'b11011;
  localparam logic [20:0] SuppBase  = 21'h10000;

endpackage

`default_nettype wire

@@ rtl/core/u2u8_enc.sv @@
// utf-16 unit encoder: surrogate tracking state and byte generation
// depends on u2u8_pkg
`default_nettype none

module u2u8_enc
  import u2u8_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  item_i,
  input  wire logic pop_i,
  output enc_t      enc_o
);

  logic       pending_q, pending_d;
  logic [9:0] held_q, held_d;

  logic [UnitW-1:0] unit;
  logic             is_low, is_high, is_pair;
  logic [20:0]      cp;

  assign unit    = item_i.code_unit;
  assign is_low  = (unit[15:10] == LowSurTag);
  assign is_high = (unit[15:10] == HighSurTag);
  assign is_pair = pending_q && is_low;
  assign cp      = SuppBase + {1'b0, held_q, unit[9:0]};

  always_comb begin
    enc_o.bytes = '0;
    enc_o.cnt   = '0;
    if (is_pair) begin
      enc_o.bytes[0] = {5'b11110, cp[20:18]};
      enc_o.bytes[1] = {2'b10, cp[17:12]};
      enc_o.bytes[2] = {2'b10, cp[11:6]};
      enc_o.bytes[3] = {2'b10, cp[5:0]};
      enc_o.cnt      = CntW'(4);
    end else if (unit[15:7] == '0) begin
      enc_o.bytes[0] = unit[7:0];
      enc_o.cnt      = CntW'(1);
    end else if (unit[15:11] == '0) begin
      enc_o.bytes[0] = {3'b110, unit[10:6]};
      enc_o.bytes[1] = {2'b10, unit[5:0]};
      enc_o.cnt      = CntW'(2);
    end else if (unit[15:11] != SurTag) begin
      enc_o.bytes[0] = {4'b1110, unit[15:12]};
      enc_o.bytes[1] = {2'b10, unit[11:6]};
      enc_o.bytes[2] = {2'b10, unit[5:0]};
      enc_o.cnt      = CntW'(3);
    end
  end

  // a high surrogate is held unless it ends the string
  always_comb begin
    pending_d = pending_q;
    held_d    = held_q;
    if (pop_i) begin
      pending_d = !is_pair && is_high && !item_i.string_end;
      held_d    = pending_d ? unit[9:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= '0;
    end else begin
      pending_q <= pending_d;
      held_q    <= held_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/u2u8_ser.sv @@
// result register that hands out encoded bytes one beat at a time
// depends on u2u8_pkg
`default_nettype none

module u2u8_ser
  import u2u8_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire enc_t enc_i,
  input  wire logic load_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic [MaxBytes-1:0][ByteW-1:0] bytes_q;
  logic [CntW-1:0]                rem_q, rem_d;
  logic [1:0]                     idx_q, idx_d;
  logic                           take;

  assign out_valid_o          = (rem_q != '0);
  assign take                 = out_valid_o && !out_stall_i;
  assign free_o               = (rem_q == '0) || (rem_q == CntW'(1) && take);
  assign out_data_o.utf8_byte = bytes_q[idx_q];
  assign out_data_o.run_last  = (rem_q == CntW'(1));

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (take) begin
      rem_d = rem_q - CntW'(1);
      idx_d = idx_q + 2'd1;
    end
    if (load_i) begin
      rem_d = enc_i.cnt;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= enc_i.bytes;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf16_to_utf8_transcoder_top.sv @@
// utf-16 to utf-8 transcoder top level: input register, encoder, byte serializer
// depends on u2u8_pkg, u2u8_enc, u2u8_ser
//
// input channel: one utf-16 code unit per beat, string_end on the last unit
// output channel: one utf-8 byte per beat, run_last on the last byte of a unit
// a unit is accepted into the input register, encoded in the next cycle and
// loaded into the result register once the serializer is free; its first byte
// is then offered and is taken when the receiver does not stall
// throughput is one output byte per cycle while the receiver does not stall, set
// by the byte serializer: a unit gives 1, 2, 3 or 4 bytes (a surrogate pair
// gives 4 on its low unit); byteless units (held high, lone low) are not loaded
// a new unit is accepted while the previous one's bytes are still going out
// reset clears the held surrogate and drops any unit or bytes in flight
// while the receiver stalls, the current byte holds and input stalls once the
// input register is full and the result register cannot take its bytes
`default_nettype none

module utf16_to_utf8_transcoder_top
  import u2u8_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic in_valid_q, in_valid_d;
  in_t  in_q;
  enc_t enc;
  logic ser_free, pop, load, accept;

  assign pop        = in_valid_q && (ser_free || enc.cnt == '0);
  assign load       = in_valid_q && ser_free && (enc.cnt != '0);
  assign in_stall_o = in_valid_q && !pop;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (pop) begin
      in_valid_d = 1'b0;
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  u2u8_enc u_enc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .pop_i  (pop),
    .enc_o  (enc)
  );

  u2u8_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enc_i       (enc),
    .load_i      (load),
    .free_o      (ser_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench for utf16_to_utf8_transcoder_top: utf-16 code units in, utf-8 byte beats out
// every output beat is checked against an in-bench encoder that keeps its own surrogate state
// depends on u2u8_pkg and the transcoder rtl
module testbench;
  import u2u8_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 20;
  localparam int PhaseUnits    = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  pending_units [$];
  out_t expected_bytes [$];
  out_t want_byte;

  logic       surr_held = 1'b0;
  logic [9:0] held_high10 = '0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_requests = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;
  bit in_taken = 1'b0;
  int idle_cycles = 0;
  int errors = 0;
  int units_accepted = 0;
  int bytes_checked = 0;
  int pairs_seen = 0;

  in_t directed_units [24] = '{
    {16'h0000, 1'b0}, {16'h007f, 1'b0}, {16'h0080, 1'b0}, {16'h07ff, 1'b0},
    {16'h0800, 1'b0}, {16'hd7ff, 1'b0}, {16'he000, 1'b0}, {16'hffff, 1'b1},
    {16'hd800, 1'b0}, {16'hdc00, 1'b0}, {16'hdbff, 1'b0}, {16'hdfff, 1'b1},
    {16'hdc00, 1'b0}, {16'hd812, 1'b0}, {16'h0041, 1'b0}, {16'hd800, 1'b0},
    {16'hdbff, 1'b0}, {16'hdc01, 1'b1}, {16'hd900, 1'b1}, {16'hdd00, 1'b0},
    {16'hd834, 1'b0}, {16'he123, 1'b0}, {16'hdfff, 1'b1}, {16'h0001, 1'b1}
  };

  always #1 clk = ~clk;

  utf16_to_utf8_transcoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // utf-8 bytes for one code unit, updating the held high surrogate
  function automatic void encode_unit(input in_t u);
    logic [7:0]  b [4];
    logic [20:0] cp;
    logic        pair;
    out_t        e;
    int          n;
    n = 0;
    pair = surr_held && (u.code_unit[15:10] == LowSurTag);
    surr_held = 1'b0;
    if (pair) begin
      cp = SuppBase + {1'b0, held_high10, u.code_unit[9:0]};
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      n = 4;
      pairs_seen++;
    end else if (u.code_unit < 16'h0080) begin
      b[0] = u.code_unit[7:0];
      n = 1;
    end else if (u.code_unit < 16'h0800) begin
      b[0] = {3'b110, u.code_unit[10:6]};
      b[1] = {2'b10, u.code_unit[5:0]};
      n = 2;
    end else if (u.code_unit[15:11] != SurTag) begin
      b[0] = {4'b1110, u.code_unit[15:12]};
      b[1] = {2'b10, u.code_unit[11:6]};
      b[2] = {2'b10, u.code_unit[5:0]};
      n = 3;
    end else if (u.code_unit[15:10] == HighSurTag) begin
      surr_held = 1'b1;
      held_high10 = u.code_unit[9:0];
    end
    if (u.string_end) begin
      surr_held = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      e.utf8_byte = b[k];
      e.run_last = (k == n - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  // one string, mostly well formed, with some broken surrogate use
  task automatic add_string(output int useful);
    in_t        s [$];
    in_t        u;
    int         chars;
    int         r;
    logic [15:0] v;
    logic [9:0] r10;
    useful = 0;
    chars = $urandom_range(1, 8);
    for (int c = 0; c < chars; c++) begin
      r = $urandom_range(99);
      u.string_end = 1'b0;
      if (r < 25) begin
        u.code_unit = 16'($urandom_range(16'h007f));
        s.push_back(u);
        useful++;
      end else if (r < 45) begin
        u.code_unit = 16'($urandom_range(16'h0080, 16'h07ff));
        s.push_back(u);
        useful++;
      end else if (r < 65) begin
        v = 16'($urandom_range(16'h0800, 16'hffff));
        if (v[15:11] == SurTag) begin
          v[13] = 1'b1;
        end
        u.code_unit = v;
        s.push_back(u);
        useful++;
      end else if (r < 88) begin
        r10 = 10'($urandom_range(1023));
        u.code_unit = {HighSurTag, r10};
        s.push_back(u);
        r10 = 10'($urandom_range(1023));
        u.code_unit = {LowSurTag, r10};
        s.push_back(u);
        useful += 2;
      end else begin
        r10 = 10'($urandom_range(1023));
        case ($urandom_range(3))
          0: begin
            u.code_unit = {LowSurTag, r10};
            s.push_back(u);
          end
          1: begin
            u.code_unit = {HighSurTag, r10};
            s.push_back(u);
          end
          2: begin
            u.code_unit = 16'($urandom_range(16'hffff));
            u.string_end = 1'($urandom_range(1));
            s.push_back(u);
          end
          default: begin
            u.code_unit = {HighSurTag, r10};
            s.push_back(u);
            r10 = 10'($urandom_range(1023));
            u.code_unit = {HighSurTag, r10};
            s.push_back(u);
          end
        endcase
      end
    end
    u = s.pop_back();
    u.string_end = 1'b1;
    s.push_back(u);
    foreach (s[i]) begin
      pending_units.push_back(s[i]);
    end
  endtask

  task automatic drain();
    while (pending_units.size() != 0 || in_valid || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // input side: beat accepted, predict its bytes
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      encode_unit(in_data);
      units_accepted++;
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_units.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data <= pending_units.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (holdoff_requests != holdoff_served) begin
      holdoff_served++;
      holdoff_left = HoldOffCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte beat: expected none, got byte %h run_last %b",
                 $time, out_data.utf8_byte, out_data.run_last);
      end else begin
        want_byte = expected_bytes.pop_front();
        bytes_checked++;
        if (out_data.utf8_byte !== want_byte.utf8_byte) begin
          errors++;
          $display("%0t: utf8_byte mismatch: expected %h, got %h",
                   $time, want_byte.utf8_byte, out_data.utf8_byte);
        end
        if (out_data.run_last !== want_byte.run_last) begin
          errors++;
          $display("%0t: run_last mismatch: expected %b, got %b",
                   $time, want_byte.run_last, out_data.run_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog: no beat for %0d cycles, %0d bytes still expected",
               $time, idle_cycles, expected_bytes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int useful;
    int total;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_units[i]) begin
      pending_units.push_back(directed_units[i]);
    end
    drain();
    for (int p = 0; p < 5; p++) begin
      case (p)
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin sender_idle_pct = 36; recv_stall_pct = 36; end
        default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      total = 0;
      while (total < PhaseUnits) begin
        add_string(useful);
        total += useful;
      end
      if (p == 4) begin
        holdoff_requests++;
      end
      drain();
    end
    repeat (DrainCycles) @(posedge clk);
    $display("checked %0d utf-8 bytes from %0d code units, %0d surrogate pairs, %0d errors",
             bytes_checked, units_accepted, pairs_seen, errors);
    $display("ran back to back, with sender gaps, receiver stalls, both, and a %0d-cycle hold-off",
             HoldOffCycles);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ utf16_to_utf8_transcoder_top.f @@
rtl/core/u2u8_pkg.sv
rtl/core/u2u8_enc.sv
rtl/core/u2u8_ser.sv
rtl/core/utf16_to_utf8_transcoder_top.sv
test/testbench.sv
